@@ design/dbrfp_pkg.sv @@
// Shared types and constants for the record field parser.
// No dependencies; used by dbrfp_serial_dec and database_record_field_parser.
`default_nettype none

package dbrfp_pkg;

  localparam int DATA_W   = 8;
  localparam int STATUS_W = 2;
  localparam int KIND_W   = 3;
  localparam int FIDX_W   = 5;
  localparam int LEN_W    = 16;
  localparam int VAL_W    = 64;
  localparam int VBYTES_W = 4;

  // Ninth varint byte is taken whole
  localparam logic [VBYTES_W-1:0] VINT_FULL_BYTE = 4'd8;

  // Serial-type classes kept in the type memory
  localparam logic [2:0] CODE_NULL = 3'd0;
  localparam logic [2:0] CODE_INT  = 3'd1;
  localparam logic [2:0] CODE_REAL = 3'd2;
  localparam logic [2:0] CODE_TEXT = 3'd3;
  localparam logic [2:0] CODE_BLOB = 3'd4;
  localparam logic [2:0] CODE_ZERO = 3'd5;
  localparam logic [2:0] CODE_ONE  = 3'd6;

  // Result status
  localparam logic [STATUS_W-1:0] STAT_FIELD = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_DONE  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_ERR   = 2'd2;

  typedef enum logic [1:0] {
    PH_HSIZE,
    PH_TYPES,
    PH_BODY,
    PH_TAIL
  } phase_t;

  typedef enum logic [1:0] {
    S_IN,
    S_RD,
    S_CHK,
    S_FIN
  } state_t;

  typedef struct packed {
    logic [2:0]       code;
    logic [LEN_W-1:0] len;
  } type_entry_t;

  typedef struct packed {
    logic                done;
    logic [VAL_W-1:0]    value;
    logic [VAL_W-1:0]    accum_next;
    logic [VBYTES_W-1:0] bytes_next;
  } vint_res_t;

  typedef struct packed {
    logic        bad;
    type_entry_t entry;
  } type_dec_t;

  // Body bytes of integer serial types 1..6
  function automatic logic [LEN_W-1:0] int_size(input logic [2:0] t);
    logic [LEN_W-1:0] n;
    unique case (t)
      3'd1:    n = 16'd1;
      3'd2:    n = 16'd2;
      3'd3:    n = 16'd3;
      3'd4:    n = 16'd4;
      3'd5:    n = 16'd6;
      3'd6:    n = 16'd8;
      default: n = 16'd0;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

@@ design/database_record_field_parser.sv @@
// Record field parser top level: header walk, type memory, body walk, result register.
// Depends on dbrfp_pkg and dbrfp_serial_dec.
//
// Usage:
//  - Byte channel (data_byte, last; byte_valid/byte_stall) carries the record payload one
//    beat per byte; last marks the final byte. Result channel (status, kind, field_index,
//    field_length, field_offset, int_value, end_of_record; result_valid/result_stall)
//    gives one beat per field, then a done or malformed beat with end_of_record set.
//  - Header and body bytes are taken one per cycle while byte_stall is low. A field's beat
//    sits in the result register in the cycle after its last body byte is taken.
//  - When a field closes or the header ends, the body walk reads the type memory: for each
//    entry an address state (S_RD), then registered read data (S_CHK), giving each
//    zero-length field on the way until it reaches the next non-empty field or runs out.
//    When the final byte started the walk, the closing done/error beat is given in S_FIN.
//  - After an error the rest of the payload is taken without results up to its last byte.
//  - Reset (rst, synchronous) empties the result register and starts a new record; the
//    type memory is not cleared, every entry is written before the walk reads it.
//  - A stalled result register holds its beat; the byte channel stalls while the result
//    register is full and stalled, and while the body walk runs.
`default_nettype none

module database_record_field_parser #(
  parameter int MAX_FIELDS = 32
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  // byte channel
  input  wire logic [dbrfp_pkg::DATA_W-1:0]           data_byte,
  input  wire logic                                   last,
  input  wire logic                                   byte_valid,
  output logic                                        byte_stall,
  // result channel
  output logic [dbrfp_pkg::STATUS_W-1:0]              status,
  output logic [dbrfp_pkg::KIND_W-1:0]                kind,
  output logic [dbrfp_pkg::FIDX_W-1:0]                field_index,
  output logic [dbrfp_pkg::LEN_W-1:0]                 field_length,
  output logic [dbrfp_pkg::LEN_W-1:0]                 field_offset,
  output logic signed [dbrfp_pkg::VAL_W-1:0]          int_value,
  output logic                                        end_of_record,
  output logic                                        result_valid,
  input  wire logic                                   result_stall
);

  localparam int CNT_W = $clog2(MAX_FIELDS + 1);
  localparam int IDX_W = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1;

  // Record state
  dbrfp_pkg::state_t                state, state_next;
  dbrfp_pkg::phase_t                phase;
  logic [dbrfp_pkg::VAL_W-1:0]      varint_accum;
  logic [dbrfp_pkg::VBYTES_W-1:0]   varint_bytes;
  logic [dbrfp_pkg::LEN_W-1:0]      header_size;
  logic [dbrfp_pkg::LEN_W-1:0]      byte_position;
  logic [dbrfp_pkg::LEN_W-1:0]      body_end;
  logic [CNT_W-1:0]                 field_count;
  logic [CNT_W-1:0]                 current_field;
  logic [dbrfp_pkg::LEN_W-1:0]      bytes_into_field;
  logic [dbrfp_pkg::VAL_W-1:0]      value_accum;
  logic                             skipping;
  logic                             pend_last;
  dbrfp_pkg::type_entry_t           cur_entry;

  // Type memory, one entry per field, registered read
  dbrfp_pkg::type_entry_t           type_mem [MAX_FIELDS];
  dbrfp_pkg::type_entry_t           rd_entry;
  logic                             mem_we;
  logic                             mem_re;

  // Decode of the current byte
  dbrfp_pkg::vint_res_t             vint;
  dbrfp_pkg::type_dec_t             tdec;
  logic [dbrfp_pkg::LEN_W:0]        pos_inc;
  logic                             hdr_end;
  logic                             t_over;
  logic                             t_full;
  logic [dbrfp_pkg::LEN_W-1:0]      bif_inc;
  logic                             body_fin;
  logic [dbrfp_pkg::VAL_W-1:0]      val_base;
  logic [dbrfp_pkg::VAL_W-1:0]      val_new;
  logic                             a_err, a_done, a_flush, a_field;
  logic                             hsz_tail;
  logic                             t_store;

  // Control
  logic                             out_free;
  logic                             take;
  logic                             walk_more;
  logic                             clr;
  logic                             emit;
  logic [dbrfp_pkg::STATUS_W-1:0]   e_status;
  logic [dbrfp_pkg::KIND_W-1:0]     e_kind;
  logic [dbrfp_pkg::FIDX_W-1:0]     e_index;
  logic [dbrfp_pkg::LEN_W-1:0]      e_len;
  logic [dbrfp_pkg::LEN_W-1:0]      e_off;
  logic [dbrfp_pkg::VAL_W-1:0]      e_val;
  logic                             e_eor;

  dbrfp_serial_dec u_dec (
    .data_byte (data_byte),
    .accum     (varint_accum),
    .nbytes    (varint_bytes),
    .vint      (vint),
    .tdec      (tdec)
  );

  assign out_free  = !result_valid || !result_stall;
  assign take      = (state == dbrfp_pkg::S_IN) && byte_valid && out_free;
  assign walk_more = current_field < field_count;

  // ---------------------------------------------------------------------------------------
  // Byte decode: what the accepted byte does to the record
  // ---------------------------------------------------------------------------------------
  always_comb begin
    a_err    = 1'b0;
    a_done   = 1'b0;
    a_flush  = 1'b0;
    a_field  = 1'b0;
    hsz_tail = 1'b0;
    t_store  = 1'b0;
    pos_inc  = {1'b0, byte_position} + 17'd1;
    hdr_end  = pos_inc >= {1'b0, header_size};
    t_over   = ({1'b0, body_end} + {1'b0, tdec.entry.len}) > 17'h0FFFF;
    t_full   = field_count >= CNT_W'(MAX_FIELDS);
    bif_inc  = bytes_into_field + 16'd1;
    body_fin = bif_inc >= cur_entry.len;
    // first integer byte sign-fills the accumulator
    val_base = (bytes_into_field == '0) ? {dbrfp_pkg::VAL_W{data_byte[7]}} : value_accum;
    val_new  = {val_base[dbrfp_pkg::VAL_W-9:0], data_byte};
    if (!skipping) begin
      unique case (phase)
        dbrfp_pkg::PH_HSIZE: begin
          if (vint.done && (|vint.value[63:16])) begin
            a_err = 1'b1;
          end else begin
            // header no longer than its own size varint: no fields
            hsz_tail = vint.done && (pos_inc >= vint.value[16:0]);
            if (last) begin
              if (hsz_tail) a_done = 1'b1;
              else          a_err  = 1'b1;
            end
          end
        end
        dbrfp_pkg::PH_TYPES: begin
          if (vint.done && (tdec.bad || t_full || t_over)) begin
            a_err = 1'b1;
          end else begin
            t_store = vint.done;
            if (hdr_end) begin
              if (!vint.done) a_err   = 1'b1;   // type varint runs past header
              else            a_flush = 1'b1;
            end else if (last) begin
              a_err = 1'b1;
            end
          end
        end
        dbrfp_pkg::PH_BODY: begin
          if (body_fin) begin
            a_field = 1'b1;
            a_flush = 1'b1;
          end else if (last) begin
            a_err = 1'b1;
          end
        end
        dbrfp_pkg::PH_TAIL: begin
          if (last) a_done = 1'b1;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      dbrfp_pkg::S_IN: begin
        if (take && a_flush) state_next = dbrfp_pkg::S_RD;
      end
      dbrfp_pkg::S_RD: begin
        state_next = walk_more ? dbrfp_pkg::S_CHK : dbrfp_pkg::S_FIN;
      end
      dbrfp_pkg::S_CHK: begin
        if (rd_entry.len != '0)  state_next = dbrfp_pkg::S_FIN;
        else if (out_free)       state_next = dbrfp_pkg::S_RD;
      end
      dbrfp_pkg::S_FIN: begin
        if (!pend_last || out_free) state_next = dbrfp_pkg::S_IN;
      end
    endcase
  end

  // ---------------------------------------------------------------------------------------
  // Sequencer: outputs (stall, memory port, result beat)
  // ---------------------------------------------------------------------------------------
  always_comb begin
    byte_stall = !((state == dbrfp_pkg::S_IN) && out_free);
    mem_we     = take && t_store;
    mem_re     = (state == dbrfp_pkg::S_RD);
    emit       = 1'b0;
    clr        = 1'b0;
    e_status   = dbrfp_pkg::STAT_FIELD;
    e_kind     = '0;
    e_index    = '0;
    e_len      = '0;
    e_off      = '0;
    e_val      = '0;
    e_eor      = 1'b0;
    unique case (state)
      dbrfp_pkg::S_IN: begin
        if (take && skipping) begin
          clr = last;
        end else if (take && (a_err || a_done)) begin
          emit     = 1'b1;
          clr      = 1'b1;
          e_status = a_err ? dbrfp_pkg::STAT_ERR : dbrfp_pkg::STAT_DONE;
          e_eor    = 1'b1;
        end else if (take && a_field) begin
          emit     = 1'b1;
          e_kind   = (cur_entry.code >= dbrfp_pkg::CODE_ZERO) ? dbrfp_pkg::CODE_INT
                                                              : cur_entry.code;
          e_index  = dbrfp_pkg::FIDX_W'(current_field);
          e_len    = cur_entry.len;
          e_off    = pos_inc[15:0] - cur_entry.len;
          if (cur_entry.code == dbrfp_pkg::CODE_ONE)      e_val = 64'd1;
          else if (cur_entry.code == dbrfp_pkg::CODE_INT) e_val = val_new;
        end
      end
      dbrfp_pkg::S_RD: begin
      end
      dbrfp_pkg::S_CHK: begin
        // zero-length field: given at the walk position
        if ((rd_entry.len == '0) && out_free) begin
          emit    = 1'b1;
          e_kind  = (rd_entry.code >= dbrfp_pkg::CODE_ZERO) ? dbrfp_pkg::CODE_INT
                                                            : rd_entry.code;
          e_index = dbrfp_pkg::FIDX_W'(current_field);
          e_off   = byte_position;
          if (rd_entry.code == dbrfp_pkg::CODE_ONE) e_val = 64'd1;
        end
      end
      dbrfp_pkg::S_FIN: begin
        if (pend_last && out_free) begin
          emit     = 1'b1;
          clr      = 1'b1;
          e_status = (phase == dbrfp_pkg::PH_TAIL) ? dbrfp_pkg::STAT_DONE
                                                   : dbrfp_pkg::STAT_ERR;
          e_eor    = 1'b1;
        end
      end
    endcase
  end

  // ---------------------------------------------------------------------------------------
  // Type memory. Entries are written in the header walk and read only after the sequencer
  // leaves S_IN, so a read never meets a write to the same entry in the same cycle.
  // ---------------------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (mem_we) type_mem[field_count[IDX_W-1:0]] <= tdec.entry;
    if (mem_re) rd_entry <= type_mem[current_field[IDX_W-1:0]];
  end

  // ---------------------------------------------------------------------------------------
  // Record state
  // ---------------------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dbrfp_pkg::S_IN;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      phase            <= dbrfp_pkg::PH_HSIZE;
      varint_accum     <= '0;
      varint_bytes     <= '0;
      header_size      <= '0;
      byte_position    <= '0;
      body_end         <= '0;
      field_count      <= '0;
      current_field    <= '0;
      bytes_into_field <= '0;
      value_accum      <= '0;
      pend_last        <= 1'b0;
    end else if (take) begin
      if (skipping || (byte_position != 16'hFFFF)) begin
        byte_position <= pos_inc[15:0];
      end
      if (!skipping) begin
        unique case (phase)
          dbrfp_pkg::PH_HSIZE: begin
            varint_accum <= vint.accum_next;
            varint_bytes <= vint.bytes_next;
            if (vint.done) begin
              header_size <= vint.value[15:0];
              body_end    <= vint.value[15:0];
              phase       <= hsz_tail ? dbrfp_pkg::PH_TAIL : dbrfp_pkg::PH_TYPES;
            end
          end
          dbrfp_pkg::PH_TYPES: begin
            varint_accum <= vint.accum_next;
            varint_bytes <= vint.bytes_next;
            if (t_store) begin
              field_count <= field_count + 1'b1;
              body_end    <= body_end + tdec.entry.len;
            end
            if (a_flush) begin
              current_field    <= '0;
              bytes_into_field <= '0;
              value_accum      <= '0;
              pend_last        <= last;
            end
          end
          dbrfp_pkg::PH_BODY: begin
            if (a_flush) begin
              current_field    <= current_field + 1'b1;
              bytes_into_field <= '0;
              value_accum      <= '0;
              pend_last        <= last;
            end else begin
              bytes_into_field <= bif_inc;
              if (cur_entry.code == dbrfp_pkg::CODE_INT) value_accum <= val_new;
            end
          end
          dbrfp_pkg::PH_TAIL: begin
          end
        endcase
      end
    end else if (state == dbrfp_pkg::S_RD) begin
      if (!walk_more) phase <= dbrfp_pkg::PH_TAIL;
    end else if (state == dbrfp_pkg::S_CHK) begin
      if (rd_entry.len != '0) begin
        phase <= dbrfp_pkg::PH_BODY;
      end else if (out_free) begin
        current_field <= current_field + 1'b1;
      end
    end
  end

  // Field the body walk is in; loaded as the walk lands on a non-empty field
  always_ff @(posedge clk) begin
    if ((state == dbrfp_pkg::S_CHK) && (rd_entry.len != '0)) cur_entry <= rd_entry;
  end

  // Swallow the rest of a malformed payload
  always_ff @(posedge clk) begin
    if (rst) begin
      skipping <= 1'b0;
    end else if (take && !skipping && a_err && !last) begin
      skipping <= 1'b1;
    end else if (clr) begin
      skipping <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      status        <= e_status;
      kind          <= e_kind;
      field_index   <= e_index;
      field_length  <= e_len;
      field_offset  <= e_off;
      int_value     <= $signed(e_val);
      end_of_record <= e_eor;
    end
  end

`ifndef SYNTH
  a_eor_status: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (end_of_record == (status != dbrfp_pkg::STAT_FIELD)))
    else $error("end_of_record disagrees with status");

  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (current_field <= field_count) && (field_count <= CNT_W'(MAX_FIELDS)))
    else $error("field walk beyond stored field count");

  a_body_entry: assert property (@(posedge clk) disable iff (rst)
    ((state == dbrfp_pkg::S_IN) && (phase == dbrfp_pkg::PH_BODY) && !skipping)
      |-> ((cur_entry.len != '0) && (bytes_into_field < cur_entry.len)))
    else $error("body walk on an empty or overrun field");

  a_no_take_in_walk: assert property (@(posedge clk) disable iff (rst)
    (take && a_flush) |=> (byte_stall && (state == dbrfp_pkg::S_RD)))
    else $error("byte taken while the field walk runs");
`endif

endmodule

`default_nettype wire

@@ design/dbrfp_serial_dec.sv @@
// Varint step and serial-type decode for the record field parser.
// Depends on dbrfp_pkg.
`default_nettype none

module dbrfp_serial_dec (
  input  wire logic [dbrfp_pkg::DATA_W-1:0]   data_byte,
  input  wire logic [dbrfp_pkg::VAL_W-1:0]    accum,
  input  wire logic [dbrfp_pkg::VBYTES_W-1:0] nbytes,
  output dbrfp_pkg::vint_res_t                vint,
  output dbrfp_pkg::type_dec_t                tdec
);

  logic [dbrfp_pkg::VAL_W-1:0] value;
  logic                        done;
  logic [dbrfp_pkg::VAL_W-1:0] text_len;

  always_comb begin
    if (nbytes >= dbrfp_pkg::VINT_FULL_BYTE) begin
      value = {accum[55:0], data_byte};
      done  = 1'b1;
    end else begin
      value = {accum[56:0], data_byte[6:0]};
      done  = !data_byte[7];
    end
    vint.done       = done;
    vint.value      = value;
    vint.accum_next = done ? '0 : value;
    vint.bytes_next = done ? '0 : nbytes + 4'd1;
  end

  // text/blob: (v - 12) / 2 bytes
  assign text_len = (value - 64'd12) >> 1;

  always_comb begin
    tdec.bad        = 1'b0;
    tdec.entry.code = dbrfp_pkg::CODE_NULL;
    tdec.entry.len  = '0;
    if (value == 64'd0) begin
      tdec.entry.code = dbrfp_pkg::CODE_NULL;
    end else if (value <= 64'd6) begin
      tdec.entry.code = dbrfp_pkg::CODE_INT;
      tdec.entry.len  = dbrfp_pkg::int_size(value[2:0]);
    end else if (value == 64'd7) begin
      tdec.entry.code = dbrfp_pkg::CODE_REAL;
      tdec.entry.len  = 16'd8;
    end else if (value == 64'd8) begin
      tdec.entry.code = dbrfp_pkg::CODE_ZERO;
    end else if (value == 64'd9) begin
      tdec.entry.code = dbrfp_pkg::CODE_ONE;
    end else if (value < 64'd12) begin
      tdec.bad = 1'b1;                      // reserved types
    end else begin
      tdec.bad        = |text_len[63:16];
      tdec.entry.len  = text_len[15:0];
      tdec.entry.code = value[0] ? dbrfp_pkg::CODE_TEXT : dbrfp_pkg::CODE_BLOB;
    end
  end

endmodule

`default_nettype wire

@@ sim/tb.sv @@
// Self-checking bench for database_record_field_parser: streams record payloads byte by byte
// and checks every field, done and malformed beat against a cycle-free predictor.
// Depends on dbrfp_pkg and the parser RTL; needs no files or arguments.
`timescale 1ns / 1ps

module tb;
  import dbrfp_pkg::*;

  localparam int MAX_FIELDS     = 32;
  localparam int RANDOM_BYTES   = 360;    // stop point for the random record stream
  localparam int LONG_BLOB      = 65530;  // body length of the long-payload record
  localparam int DRAIN_CYCLES   = 80;     // outlasts the longest field walk
  localparam int WATCHDOG_LIMIT = 2000;   // cycles with no beat on either channel

  // Record shapes for the random stream
  typedef enum int {
    REC_GOOD,
    REC_TRUNC,
    REC_RESERVED,
    REC_CROWDED,
    REC_HUGE,
    REC_SKEWED,
    REC_NOISE
  } rec_mode_t;

  typedef struct packed {
    logic [STATUS_W-1:0] stat;
    logic [KIND_W-1:0]   kind;
    logic [FIDX_W-1:0]   idx;
    logic [LEN_W-1:0]    len;
    logic [LEN_W-1:0]    off;
    logic [VAL_W-1:0]    val;
    logic                eor;
  } field_result_t;

  logic                clk;
  logic                rst;
  logic [DATA_W-1:0]   data_byte;
  logic                last;
  logic                byte_valid;
  logic                byte_stall;
  logic [STATUS_W-1:0] status;
  logic [KIND_W-1:0]   kind;
  logic [FIDX_W-1:0]   field_index;
  logic [LEN_W-1:0]    field_length;
  logic [LEN_W-1:0]    field_offset;
  logic signed [VAL_W-1:0] int_value;
  logic                end_of_record;
  logic                result_valid;
  logic                result_stall;

  database_record_field_parser #(
    .MAX_FIELDS(MAX_FIELDS)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .data_byte    (data_byte),
    .last         (last),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .status       (status),
    .kind         (kind),
    .field_index  (field_index),
    .field_length (field_length),
    .field_offset (field_offset),
    .int_value    (int_value),
    .end_of_record(end_of_record),
    .result_valid (result_valid),
    .result_stall (result_stall)
  );

  // Beats still owed by the DUT, oldest first
  field_result_t expected_beats[$];
  // Payload of the record being built, first byte first
  logic [7:0]    rec_bytes[$];

  bit idle_on;     // gates random gaps on both channels
  int bytes_sent;
  int fail_count;

  // ---------------------------------------------------------------------------------------
  // Parser state mirror
  // ---------------------------------------------------------------------------------------
  phase_t      rec_phase;
  logic [63:0] vint_acc;
  int          vint_cnt;
  int          hdr_size;
  int          rec_pos;     // byte offset from payload start, saturates at 65535
  logic [2:0]  fld_code[0:MAX_FIELDS-1];
  logic [15:0] fld_len[0:MAX_FIELDS-1];
  int          field_cnt;
  int          walk_idx;    // field the body walk sits on
  int          walk_bytes;  // body bytes taken for that field
  logic [63:0] walk_val;    // integer value being assembled
  int          body_end;
  bit          swallow;     // dropping the rest of a malformed payload

  function automatic void clear_record();
    rec_phase  = PH_HSIZE;
    vint_acc   = '0;
    vint_cnt   = 0;
    hdr_size   = 0;
    rec_pos    = 0;
    field_cnt  = 0;
    walk_idx   = 0;
    walk_bytes = 0;
    walk_val   = '0;
    body_end   = 0;
  endfunction

  // One varint byte: 7 bits each for bytes 1..8, the ninth byte is taken whole.
  function automatic bit vint_take(input logic [7:0] b, output logic [63:0] v);
    bit fin;
    fin = 1'b0;
    if (vint_cnt >= 8) begin
      vint_acc = {vint_acc[55:0], b};
      fin = 1'b1;
    end else begin
      vint_acc = {vint_acc[56:0], b[6:0]};
      if (!b[7]) fin = 1'b1;
      else vint_cnt++;
    end
    v = vint_acc;
    if (fin) begin
      vint_acc = '0;
      vint_cnt = 0;
    end
    return fin;
  endfunction

  function automatic void push_field(input int offset);
    field_result_t r;
    r = '0;
    r.stat = STAT_FIELD;
    // zero/one constants report as integers
    r.kind = (fld_code[walk_idx] >= CODE_ZERO) ? CODE_INT : fld_code[walk_idx];
    r.idx  = walk_idx[4:0];
    r.len  = fld_len[walk_idx];
    r.off  = offset[15:0];
    if (fld_code[walk_idx] == CODE_ONE) r.val = 64'd1;
    else if (fld_code[walk_idx] == CODE_INT && fld_len[walk_idx] != 0) r.val = walk_val;
    expected_beats.push_back(r);
  endfunction

  function automatic void push_close(input logic [STATUS_W-1:0] st);
    field_result_t r;
    r = '0;
    r.stat = st;
    r.eor  = 1'b1;
    expected_beats.push_back(r);
  endfunction

  // Emit every zero-length field at the walk position, then pick body or tail.
  function automatic void flush_empty(input int offset);
    while (walk_idx < field_cnt && fld_len[walk_idx] == 0) begin
      push_field(offset);
      walk_idx++;
    end
    rec_phase = (walk_idx < field_cnt) ? PH_BODY : PH_TAIL;
  endfunction

  // Advance the mirror by one accepted beat and queue the beats it causes.
  function automatic void predict_byte(input logic [7:0] b, input bit is_last);
    int          p;
    int          flen;
    bit          err;
    bit          fin;
    bit          got;
    logic [63:0] v;
    logic [63:0] l;
    logic [2:0]  code;
    p   = rec_pos;
    err = 1'b0;
    fin = 1'b0;
    if (swallow) begin
      if (is_last) begin
        clear_record();
        swallow = 1'b0;
      end else if (rec_pos < 65535) begin
        rec_pos++;
      end
      return;
    end
    case (rec_phase)
      PH_HSIZE: begin
        if (vint_take(b, v)) begin
          if (v > 64'hFFFF) begin
            err = 1'b1;
          end else begin
            hdr_size  = v[31:0];
            body_end  = hdr_size;
            // header size not past its own varint: record with no fields
            rec_phase = (p + 1 >= hdr_size) ? PH_TAIL : PH_TYPES;
          end
        end
      end
      PH_TYPES: begin
        got = vint_take(b, v);
        if (got) begin
          flen = 0;
          code = CODE_NULL;
          if (field_cnt >= MAX_FIELDS) err = 1'b1;
          else if (v == 0) code = CODE_NULL;
          else if (v <= 6) begin
            code = CODE_INT;
            case (v[2:0])
              3'd5:    flen = 6;
              3'd6:    flen = 8;
              default: flen = v[2:0];
            endcase
          end else if (v == 7) begin
            code = CODE_REAL;
            flen = 8;
          end else if (v == 8) code = CODE_ZERO;
          else if (v == 9) code = CODE_ONE;
          else if (v < 12) err = 1'b1;  // reserved types
          else begin
            l = (v - 64'd12) >> 1;
            if (l > 64'hFFFF) err = 1'b1;
            else begin
              flen = l[31:0];
              code = v[0] ? CODE_TEXT : CODE_BLOB;
            end
          end
          if (!err && body_end + flen > 65535) err = 1'b1;
          if (!err) begin
            body_end += flen;
            fld_code[field_cnt] = code;
            fld_len[field_cnt]  = flen[15:0];
            field_cnt++;
          end
        end
        if (!err && p + 1 >= hdr_size) begin
          if (!got) begin
            err = 1'b1;  // type varint runs past the header
          end else begin
            walk_idx   = 0;
            walk_bytes = 0;
            walk_val   = '0;
            flush_empty(p + 1);
          end
        end
      end
      PH_BODY: begin
        if (fld_code[walk_idx] == CODE_INT) begin
          if (walk_bytes == 0) walk_val = b[7] ? '1 : '0;
          walk_val = {walk_val[55:0], b};
        end
        walk_bytes++;
        if (walk_bytes >= fld_len[walk_idx]) begin
          push_field(p + 1 - fld_len[walk_idx]);
          walk_idx++;
          walk_bytes = 0;
          walk_val   = '0;
          flush_empty(p + 1);
        end
      end
      default: ;  // tail: trailing bytes dropped
    endcase
    if (!err && is_last) begin
      if (rec_phase == PH_TAIL) fin = 1'b1;
      else err = 1'b1;  // payload ended early
    end
    if (err) begin
      push_close(STAT_ERR);
      clear_record();
      swallow = !is_last;
    end else if (fin) begin
      push_close(STAT_DONE);
      clear_record();
    end else if (rec_pos < 65535) begin
      rec_pos++;
    end
  endfunction

  // ---------------------------------------------------------------------------------------
  // Record construction
  // ---------------------------------------------------------------------------------------
  // Random byte biased toward the sign and range edges.
  function automatic logic [7:0] rand_byte();
    logic [7:0] r;
    r = $urandom_range(0, 255);
    case ($urandom_range(0, 5))
      0:       r = 8'h00;
      1:       r = 8'hFF;
      2:       r = $urandom_range(0, 1) ? 8'h7F : 8'h80;
      default: ;
    endcase
    return r;
  endfunction

  function automatic int vint_len(input logic [63:0] v);
    int n;
    n = 1;
    while (n < 8 && (v >> (7 * n)) != 0) n++;
    if (n == 8 && (v >> 56) != 0) n = 9;
    return n;
  endfunction

  // Encode v in exactly nb bytes; more bytes than needed pads with leading 0x80.
  function automatic void push_vint(input logic [63:0] v, input int nb);
    logic [63:0] t;
    int          k;
    if (nb == 9) begin
      for (k = 7; k >= 0; k--) begin
        t = v >> (8 + 7 * k);
        rec_bytes.push_back({1'b1, t[6:0]});
      end
      rec_bytes.push_back(v[7:0]);
    end else begin
      for (k = nb - 1; k >= 1; k--) begin
        t = v >> (7 * k);
        rec_bytes.push_back({1'b1, t[6:0]});
      end
      rec_bytes.push_back({1'b0, v[6:0]});
    end
  endfunction

  // Build one payload into rec_bytes. Good records are header + types + body (+ tail);
  // most other shapes break one thing on top of that; noise records are random bytes.
  function automatic void build_record(input int nf, input rec_mode_t mode);
    logic [63:0] st_val[$];
    int          st_nb[$];
    int          lens[$];
    logic [63:0] v;
    int          i;
    int          sel;
    int          flen;
    int          tbytes;
    int          h;
    int          hv;
    int          bad_at;
    bit          one_huge;
    rec_bytes.delete();
    if (mode == REC_NOISE) begin
      repeat ($urandom_range(1, 6)) rec_bytes.push_back(rand_byte());
      return;
    end
    bad_at   = (mode == REC_HUGE) ? $urandom_range(0, nf - 2) :
               (nf > 0) ? $urandom_range(0, nf - 1) : 0;
    one_huge = $urandom_range(0, 1);
    tbytes   = 0;
    for (i = 0; i < nf; i++) begin
      sel = $urandom_range(0, 11);
      // long records lean on zero-length types to stay short
      if (nf > 8 && $urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 2))
          0:       sel = 0;
          1:       sel = 8;
          default: sel = 9;
        endcase
      end
      flen = 0;
      if (sel <= 9) begin
        v = sel;
        case (sel)
          1, 2, 3, 4: flen = sel;
          5:          flen = 6;
          6, 7:       flen = 8;
          default:    flen = 0;
        endcase
      end else begin
        flen = ($urandom_range(0, 29) == 0) ? $urandom_range(7, 200) : $urandom_range(0, 6);
        v = 12 + 2 * flen + ((sel == 10) ? 1 : 0);
      end
      if (mode == REC_RESERVED && i == bad_at) begin
        v = 10 + $urandom_range(0, 1);
        flen = 0;
      end
      if (mode == REC_HUGE && (i == bad_at || (i == bad_at + 1 && !one_huge))) begin
        // one length past 16 bits, or two that overflow the body end together
        flen = one_huge ? 65536 + $urandom_range(0, 1000) : $urandom_range(33000, 65535);
        v = 12 + 2 * flen + $urandom_range(0, 1);
      end
      st_val.push_back(v);
      st_nb.push_back(($urandom_range(0, 7) == 0) ? $urandom_range(vint_len(v), 9) :
                      vint_len(v));
      lens.push_back(flen);
      tbytes += st_nb[i];
    end
    h = 1;
    while (vint_len(h + tbytes) > h) h++;
    if ($urandom_range(0, 7) == 0) h = $urandom_range(h, 9);
    hv = h + tbytes;
    if (mode == REC_SKEWED) begin
      hv = hv + ($urandom_range(0, 1) ? 1 : -1) * $urandom_range(1, 2);
      if (hv < 0) hv = 0;
      if (vint_len(hv) > h) h = vint_len(hv);
    end
    push_vint(hv, h);
    for (i = 0; i < nf; i++) push_vint(st_val[i], st_nb[i]);
    if (mode == REC_HUGE) begin
      repeat ($urandom_range(1, 3)) rec_bytes.push_back(rand_byte());
    end else begin
      for (i = 0; i < nf; i++) repeat (lens[i]) rec_bytes.push_back(rand_byte());
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 3)) rec_bytes.push_back(rand_byte());
      end
    end
    if (mode == REC_TRUNC && rec_bytes.size() >= 2) begin
      repeat ($urandom_range(1, rec_bytes.size() - 1)) void'(rec_bytes.pop_back());
    end
  endfunction

  // ---------------------------------------------------------------------------------------
  // Byte channel driver
  // ---------------------------------------------------------------------------------------
  // Present one beat, hold it through stall, then update the mirror at the accepting edge.
  task automatic send_byte(input logic [7:0] b, input bit is_last);
    if (idle_on && $urandom_range(0, 9) == 0) begin
      byte_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    byte_valid <= 1'b1;
    data_byte  <= b;
    last       <= is_last;
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    predict_byte(b, is_last);
    bytes_sent++;
  endtask

  task automatic send_record();
    int i;
    for (i = 0; i < rec_bytes.size(); i++) send_byte(rec_bytes[i], i == rec_bytes.size() - 1);
  endtask

  // ---------------------------------------------------------------------------------------
  // Directed tests
  // ---------------------------------------------------------------------------------------
  // Header size 0 and 1: no fields, done on the only byte
  task automatic test_empty_records();
    rec_bytes = '{8'h00};
    send_record();
    rec_bytes = '{8'h01};
    send_record();
  endtask

  // Type 11 is reserved; the bytes after the error are swallowed up to last
  task automatic test_reserved_type();
    rec_bytes = '{8'h02, 8'h0B, 8'h55, 8'hAA};
    send_record();
  endtask

  // Type varint still open (0x81) when the header ends
  task automatic test_open_type_varint();
    rec_bytes = '{8'h02, 8'h81, 8'h00};
    send_record();
  endtask

  // 1-byte int 0xFF -> -1, then constants 0 and 1 given at the same offset
  task automatic test_int_constants();
    rec_bytes = '{8'h04, 8'h01, 8'h08, 8'h09, 8'hFF};
    send_record();
  endtask

  // Payload ends inside the header
  task automatic test_truncated_header();
    rec_bytes = '{8'h03, 8'h06};
    send_record();
  endtask

  // Header size 65536 does not fit 16 bits
  task automatic test_oversize_header();
    rec_bytes = '{8'h84, 8'h80, 8'h00, 8'h7E};
    send_record();
  endtask

  // One null field, then bytes past the body that are ignored
  task automatic test_trailing_bytes();
    rec_bytes = '{8'h02, 8'h00, 8'h33, 8'h44};
    send_record();
  endtask

  // Random records: each broken shape once up front, then a mix led by good records.
  task automatic test_random_records();
    int        start;
    int        k;
    int        nf;
    rec_mode_t mode;
    start = bytes_sent;
    k = 0;
    while (bytes_sent - start < RANDOM_BYTES) begin
      idle_on = ($urandom_range(0, 3) != 0);
      case (k)
        0: mode = REC_CROWDED;
        1: mode = REC_HUGE;
        2: mode = REC_RESERVED;
        3: mode = REC_SKEWED;
        4: mode = REC_TRUNC;
        5: mode = REC_NOISE;
        6: mode = REC_GOOD;
        default: begin
          case ($urandom_range(0, 19))
            13:      mode = REC_TRUNC;
            14:      mode = REC_RESERVED;
            15:      mode = REC_CROWDED;
            16:      mode = REC_HUGE;
            17:      mode = REC_SKEWED;
            18, 19:  mode = REC_NOISE;
            default: mode = REC_GOOD;
          endcase
        end
      endcase
      case (mode)
        REC_CROWDED:  nf = MAX_FIELDS + 1 + $urandom_range(0, 1);
        REC_HUGE:     nf = $urandom_range(2, 6);
        REC_RESERVED: nf = $urandom_range(1, 6);
        default:      nf = ($urandom_range(0, 9) == 0) ? $urandom_range(9, MAX_FIELDS) :
                           $urandom_range(0, 8);
      endcase
      if (k == 6) nf = MAX_FIELDS;  // full record: field index reaches 31
      build_record(nf, mode);
      send_record();
      k++;
    end
  endtask

  // One blob filling the 16-bit body; trailing bytes push the position into saturation
  task automatic test_long_payload();
    rec_bytes.delete();
    push_vint(64'd4, 1);
    push_vint(64'd12 + 2 * LONG_BLOB, 3);
    repeat (LONG_BLOB + 3) rec_bytes.push_back(rand_byte());
    send_record();
  endtask

  // ---------------------------------------------------------------------------------------
  // Clock, result-side stall, checker, watchdog
  // ---------------------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result stall in random bursts while idling is on
  initial begin
    result_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 7) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        result_stall <= 1'b0;
      end
    end
  end

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Every accepted result beat is matched against the oldest expectation
  always @(posedge clk) begin : result_check
    field_result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_beats.size() == 0) begin
        $display("%0t: unexpected beat: expected none, got status %0h", $time, status);
        fail_count++;
      end else begin
        want = expected_beats.pop_front();
        check_field("status", want.stat, status);
        check_field("kind", want.kind, kind);
        check_field("field_index", want.idx, field_index);
        check_field("field_length", want.len, field_length);
        check_field("field_offset", want.off, field_offset);
        check_field("int_value", want.val, int_value);
        check_field("end_of_record", want.eor, end_of_record);
      end
    end
  end

  // Ends the run when neither channel moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((byte_valid && !byte_stall) || (result_valid && !result_stall)) quiet = 0;
      else quiet++;
    end
    $display("tb: FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------------------
  initial begin
    rst        <= 1'b1;
    byte_valid <= 1'b0;
    data_byte  <= '0;
    last       <= 1'b0;
    idle_on    = 1'b1;
    bytes_sent = 0;
    fail_count = 0;
    for (int i = 0; i < MAX_FIELDS; i++) begin
      fld_code[i] = CODE_NULL;
      fld_len[i]  = '0;
    end
    swallow = 1'b0;
    clear_record();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_empty_records();
    test_reserved_type();
    test_open_type_varint();
    test_int_constants();
    test_truncated_header();
    test_oversize_header();
    test_trailing_bytes();
    test_random_records();
    // final stretch runs at full rate on both sides
    idle_on = 1'b0;
    test_long_payload();
    byte_valid <= 1'b0;

    while (expected_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

endmodule
